### rtl/core/rect_region_done_tracker_top_macros.svh
// assertion macros for the rectangle done-bitmap tracker
// included by rect_region_done_tracker_top.sv, no other dependencies
`ifndef RECT_REGION_DONE_TRACKER_TOP_MACROS_SVH
`define RECT_REGION_DONE_TRACKER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RRDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RRDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/rrdt_pkg.sv
// shared types and constants for the rectangle done-bitmap tracker
// no dependencies
package rrdt_pkg;

    localparam int COORD_W    = 16;
    localparam int DIM_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // widest row mask and row addressing over the supported store sizes
    localparam int MASK_W     = 64;
    localparam int ROW_IDX_W  = 10;
    localparam int ROW_CNT_W  = 11;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIM_W-1:0] WIN_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_H    = 3'd3;

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_MARK  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic                   err;
        logic [MASK_W-1:0]      mask;
        logic [ROW_IDX_W-1:0]   row_first;
        logic [ROW_CNT_W-1:0]   row_cnt;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

### rtl/core/rrdt_if.sv
// command and result channel interfaces for the done-bitmap tracker
// depends on rrdt_pkg
interface rrdt_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [rrdt_pkg::COORD_W-1:0]  x_lo;
    logic [rrdt_pkg::COORD_W-1:0]  x_hi;
    logic [rrdt_pkg::COORD_W-1:0]  y_lo;
    logic [rrdt_pkg::COORD_W-1:0]  y_hi;

    modport source (output valid, command, x_lo, x_hi, y_lo, y_hi, input ready);
    modport sink   (input valid, command, x_lo, x_hi, y_lo, y_hi, output ready);
endinterface

interface rrdt_res_if;
    logic valid;
    logic ready;
    logic need_compute;
    logic range_error;

    modport source (output valid, need_compute, range_error, input ready);
    modport sink   (input valid, need_compute, range_error, output ready);
endinterface

### rtl/core/rrdt_front.sv
// front end: window registers, command accept and classification
// depends on rrdt_pkg and rrdt_if
module rrdt_front #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rrdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rrdt_cmd_if.sink                          i_cmd,
    input  rrdt_pkg::t_q_stat                 i_q_stat,
    input  rrdt_pkg::t_back_stat              i_back_stat,
    output logic                              o_push,
    output rrdt_pkg::t_op                     o_op
);
    localparam int XW  = rrdt_pkg::COORD_W + 1;
    localparam int CRW = $clog2(MAX_COLS + 1);
    localparam int RA  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);

    logic [rrdt_pkg::COORD_W-1:0] r_origin_x;
    logic [rrdt_pkg::COORD_W-1:0] r_origin_y;
    logic [rrdt_pkg::DIM_W-1:0]   r_win_w;
    logic [rrdt_pkg::DIM_W-1:0]   r_win_h;

    logic [XW-1:0]                w_eff_w;
    logic [XW-1:0]                w_eff_h;
    logic [XW-1:0]                w_x_end;
    logic [XW-1:0]                w_y_end;
    logic                         w_err;
    logic                         w_empty;
    logic [rrdt_pkg::COORD_W-1:0] w_x_lo_d;
    logic [rrdt_pkg::COORD_W-1:0] w_x_hi_d;
    logic [rrdt_pkg::COORD_W-1:0] w_y_lo_d;
    logic [rrdt_pkg::COORD_W-1:0] w_y_cnt;
    rrdt_pkg::t_cmd               w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_win_w    <= rrdt_pkg::WIN_RESET;
            r_win_h    <= rrdt_pkg::WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rrdt_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                rrdt_pkg::REG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                rrdt_pkg::REG_WIN_W:    r_win_w <= i_cfg_data[rrdt_pkg::DIM_W-1:0];
                rrdt_pkg::REG_WIN_H:    r_win_h <= i_cfg_data[rrdt_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        // window saturates at the store size
        w_eff_w = (32'(r_win_w) > MAX_COLS) ? XW'(MAX_COLS) : XW'(r_win_w);
        w_eff_h = (32'(r_win_h) > MAX_ROWS) ? XW'(MAX_ROWS) : XW'(r_win_h);
        w_x_end = {1'b0, r_origin_x} + w_eff_w;
        w_y_end = {1'b0, r_origin_y} + w_eff_h;

        w_err = (i_cmd.x_lo < r_origin_x) || ({1'b0, i_cmd.x_hi} > w_x_end)
             || (i_cmd.y_lo < r_origin_y) || ({1'b0, i_cmd.y_hi} > w_y_end);
        w_empty = (i_cmd.x_hi <= i_cmd.x_lo) || (i_cmd.y_hi <= i_cmd.y_lo);

        w_x_lo_d = i_cmd.x_lo - r_origin_x;
        w_x_hi_d = i_cmd.x_hi - r_origin_x;
        w_y_lo_d = i_cmd.y_lo - r_origin_y;
        w_y_cnt  = i_cmd.y_hi - i_cmd.y_lo;
        w_cmd    = rrdt_pkg::t_cmd'(i_cmd.command);

        for (int c = 0; c < rrdt_pkg::MASK_W; c++) begin
            o_op.mask[c] = (c < MAX_COLS)
                        && (CRW'(c) >= w_x_lo_d[CRW-1:0])
                        && (CRW'(c) <  w_x_hi_d[CRW-1:0]);
        end
        o_op.row_first = rrdt_pkg::ROW_IDX_W'(w_y_lo_d[RA-1:0]);
        o_op.row_cnt   = rrdt_pkg::ROW_CNT_W'(w_y_cnt[RCW-1:0]);
        o_op.err       = 1'b0;

        priority if (w_cmd == rrdt_pkg::CMD_CLEAR) begin
            o_op.kind = rrdt_pkg::OP_CLEAR;
        end else if (w_cmd == rrdt_pkg::CMD_RSVD) begin
            o_op.kind = rrdt_pkg::OP_NOP;
        end else if (w_err) begin
            o_op.kind = rrdt_pkg::OP_NOP;
            o_op.err  = 1'b1;
        end else if (w_empty) begin
            o_op.kind = rrdt_pkg::OP_NOP;
        end else if (w_cmd == rrdt_pkg::CMD_MARK) begin
            o_op.kind = rrdt_pkg::OP_MARK;
        end else begin
            o_op.kind = rrdt_pkg::OP_QUERY;
        end
    end

    assign i_cmd.ready = !i_q_stat.full && !i_back_stat.init_busy;
    assign o_push      = i_cmd.valid && i_cmd.ready;

endmodule

### rtl/core/rrdt_queue.sv
// short queue of classified operations between front and back
// depends on rrdt_pkg
module rrdt_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rrdt_pkg::t_op         i_op,
    input  logic                  i_pop,
    output rrdt_pkg::t_op         o_op,
    output rrdt_pkg::t_q_stat     o_stat
);
    localparam int PW = $clog2(rrdt_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(rrdt_pkg::QUEUE_DEPTH + 1);

    rrdt_pkg::t_op  r_slot [rrdt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_op         = r_slot[r_rp];
    assign o_stat.full  = (r_cnt == CW'(rrdt_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

### rtl/core/rrdt_back.sv
// back end: bitmap store, row sweeps for mark/query/clear, result register
// depends on rrdt_pkg and rrdt_if
module rrdt_back #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rrdt_pkg::t_op          i_op,
    input  rrdt_pkg::t_q_stat      i_q_stat,
    output logic                   o_pop,
    output rrdt_pkg::t_back_stat   o_stat,
    rrdt_res_if.source             o_res
);
    localparam int RA  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int RCW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_CLR  = 4'b0100,
        ST_RESP = 4'b1000
    } t_state;

    logic [MAX_COLS-1:0]  mem [MAX_ROWS];

    t_state               r_state;
    rrdt_pkg::t_op_kind   r_kind;
    logic [MAX_COLS-1:0]  r_mask;
    logic [RA-1:0]        r_row;
    logic [RCW-1:0]       r_left;
    logic                 r_pend;
    logic [RA-1:0]        r_pend_row;
    logic [MAX_COLS-1:0]  r_rdata;
    logic                 r_need;
    logic                 r_err;
    logic                 r_reply;

    logic                 w_we;
    logic [RA-1:0]        w_wa;
    logic [MAX_COLS-1:0]  w_wd;
    logic                 w_hole;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_row;
        w_wd = '0;
        if (r_state == ST_CLR) begin
            w_we = 1'b1;
        end else if (r_state == ST_RUN && r_pend && r_kind == rrdt_pkg::OP_MARK) begin
            w_we = 1'b1;
            w_wa = r_pend_row;
            w_wd = r_rdata | r_mask;
        end
    end

    assign w_hole = ((r_rdata & r_mask) != r_mask);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rdata <= mem[r_row];
    end

    assign o_pop = (r_state == ST_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_row   <= '0;
            r_pend  <= 1'b0;
            r_reply <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_kind <= i_op.kind;
                        r_mask <= i_op.mask[MAX_COLS-1:0];
                        r_row  <= i_op.row_first[RA-1:0];
                        r_left <= i_op.row_cnt[RCW-1:0];
                        r_need <= 1'b0;
                        r_err  <= i_op.err;
                        unique case (i_op.kind)
                            rrdt_pkg::OP_MARK,
                            rrdt_pkg::OP_QUERY: r_state <= ST_RUN;
                            rrdt_pkg::OP_CLEAR: begin
                                r_row   <= '0;
                                r_reply <= 1'b1;
                                r_state <= ST_CLR;
                            end
                            rrdt_pkg::OP_NOP:   r_state <= ST_RESP;
                        endcase
                    end
                end
                ST_RUN: begin
                    // read issue and update of the previous row overlap
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_pend_row <= r_row;
                        r_row      <= r_row + 1'b1;
                        r_left     <= r_left - 1'b1;
                    end
                    if (r_pend && r_kind == rrdt_pkg::OP_QUERY && w_hole) begin
                        r_need <= 1'b1;
                    end
                    if (r_left == '0 && !r_pend) begin
                        r_state <= ST_RESP;
                    end
                end
                ST_CLR: begin
                    if (r_row == RA'(MAX_ROWS - 1)) begin
                        r_row   <= '0;
                        r_reply <= 1'b0;
                        r_state <= r_reply ? ST_RESP : ST_IDLE;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                ST_RESP: begin
                    if (o_res.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stat.init_busy  = (r_state == ST_CLR) && !r_reply;
    assign o_res.valid        = (r_state == ST_RESP);
    assign o_res.need_compute = r_need;
    assign o_res.range_error  = r_err;

endmodule

### rtl/core/rect_region_done_tracker_top.sv
// top level of the rectangle done-bitmap tracker
// depends on rrdt_pkg, rrdt_if, rrdt_front, rrdt_queue, rrdt_back and the macros header
//
// usage
//   i_cmd carries one command per transfer: mark, query or clear, with a half-open
//   rectangle [x_lo,x_hi) x [y_lo,y_hi) in absolute coordinates
//   o_res returns exactly one result per command: need_compute, range_error
//   window registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle
// operation flow
//   the front classifies a command in the cycle of its transfer and queues it
//   mark and query walk the bitmap memory one row per cycle through its one read
//   port and one write port
//   clear sweeps all MAX_ROWS rows to zero before its result is valid
//   out-of-window, empty and unused commands go straight to result valid
//   the back end takes the next command from the queue only in its idle state,
//   after the previous result has been taken
// reset
//   after reset the store is swept to zero, all MAX_ROWS rows; i_cmd.ready
//   stays low during that pass, configuration writes are taken throughout
// stall
//   a stalled result holds in the output register; up to two further commands
//   are taken into the queue before i_cmd.ready drops
module rect_region_done_tracker_top #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rrdt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rrdt_cmd_if.sink                          i_cmd,
    rrdt_res_if.source                        o_res
);
    `include "rect_region_done_tracker_top_macros.svh"

    // classified operation into and out of the queue
    rrdt_pkg::t_op          w_op_in;
    rrdt_pkg::t_op          w_op_out;
    logic                   w_push;
    logic                   w_pop;
    rrdt_pkg::t_q_stat      w_q_stat;
    rrdt_pkg::t_back_stat   w_back_stat;

    // front: window registers, range check, row mask
    rrdt_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_q_stat    (w_q_stat),
        .i_back_stat (w_back_stat),
        .o_push      (w_push),
        .o_op        (w_op_in)
    );

    // decoupling queue
    rrdt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op_in),
        .i_pop   (w_pop),
        .o_op    (w_op_out),
        .o_stat  (w_q_stat)
    );

    // back: bitmap memory and row sweeps
    rrdt_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op_out),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_stat   (w_back_stat),
        .o_res    (o_res)
    );

    // no command is taken while the reset sweep runs
    `RRDT_ASSERT_IMPL(a_no_take_in_init, i_clk, i_rst_n, w_back_stat.init_busy, !i_cmd.ready, "command taken during reset sweep")
    // the back end never pops an empty queue
    `RRDT_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")
    // a full queue stays full until the back end pops
    `RRDT_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, w_q_stat.full && !w_pop, w_q_stat.full, "full queue drained without pop")

endmodule

### dv/rect_region_done_tracker_top_test.sv
`timescale 1ns / 100ps
// self-checking bench for rect_region_done_tracker_top: directed and random mark, query
// and clear transfers over several window settings, checked against a bitmap predictor
// depends on rrdt_pkg, rrdt_if and the tracker rtl
module rect_region_done_tracker_top_test;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COORD_MAX   = 65535;
    localparam int QUIET_LIMIT = 3000;   // cycles without any transfer or register write
    localparam int ERR_SHOWN   = 10;

    typedef struct packed {
        logic need_compute;
        logic range_error;
    } t_rect_outcome;

    // done-bitmap predictor plus the queue of outcomes still owed by the block
    class done_bitmap_board;
        bit [MAX_COLS-1:0]          done_map [MAX_ROWS];
        bit [rrdt_pkg::COORD_W-1:0] org_x;
        bit [rrdt_pkg::COORD_W-1:0] org_y;
        bit [rrdt_pkg::DIM_W-1:0]   win_w;
        bit [rrdt_pkg::DIM_W-1:0]   win_h;
        t_rect_outcome              outstanding [$];
        int unsigned                mismatches;

        function new();
            wipe();
            org_x      = '0;
            org_y      = '0;
            win_w      = rrdt_pkg::WIN_RESET;
            win_h      = rrdt_pkg::WIN_RESET;
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (done_map[r]) done_map[r] = '0;
        endfunction

        // oversized windows saturate to the store size
        function int unsigned eff_w();
            return (win_w > MAX_COLS) ? MAX_COLS : int'(win_w);
        endfunction

        function int unsigned eff_h();
            return (win_h > MAX_ROWS) ? MAX_ROWS : int'(win_h);
        endfunction

        function void write_reg(logic [rrdt_pkg::CFG_IDX_W-1:0] idx,
                                logic [rrdt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rrdt_pkg::REG_ORIGIN_X: org_x = data;
                rrdt_pkg::REG_ORIGIN_Y: org_y = data;
                rrdt_pkg::REG_WIN_W:    win_w = data[rrdt_pkg::DIM_W-1:0];
                rrdt_pkg::REG_WIN_H:    win_h = data[rrdt_pkg::DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function t_rect_outcome predict_outcome(rrdt_pkg::t_cmd cmd,
                                                bit [rrdt_pkg::COORD_W-1:0] xl,
                                                bit [rrdt_pkg::COORD_W-1:0] xh,
                                                bit [rrdt_pkg::COORD_W-1:0] yl,
                                                bit [rrdt_pkg::COORD_W-1:0] yh);
            t_rect_outcome     res;
            int unsigned       x_end;
            int unsigned       y_end;
            int unsigned       n;
            int unsigned       r;
            bit [MAX_COLS-1:0] span;
            res   = '0;
            x_end = org_x + eff_w();
            y_end = org_y + eff_h();
            if (cmd == rrdt_pkg::CMD_CLEAR) begin
                wipe();
                return res;
            end
            if (cmd == rrdt_pkg::CMD_RSVD) return res;
            if (xl < org_x || xh > x_end || yl < org_y || yh > y_end) begin
                res.range_error = 1'b1;
            end else if (xh > xl && yh > yl) begin
                // column span relative to the window origin
                n    = xh - xl;
                span = (n >= MAX_COLS) ? '1 : ((MAX_COLS'(1) << n) - 1'b1);
                span = span << (xl - org_x);
                for (r = yl - org_y; r < int'(yh - org_y) && r < MAX_ROWS; r++) begin
                    if (cmd == rrdt_pkg::CMD_MARK) begin
                        done_map[r] |= span;
                    end else if ((done_map[r] & span) != span) begin
                        res.need_compute = 1'b1;
                        break;
                    end
                end
            end
            return res;
        endfunction

        function void note_command(rrdt_pkg::t_cmd cmd, bit [rrdt_pkg::COORD_W-1:0] xl,
                                   bit [rrdt_pkg::COORD_W-1:0] xh,
                                   bit [rrdt_pkg::COORD_W-1:0] yl,
                                   bit [rrdt_pkg::COORD_W-1:0] yh);
            outstanding.push_back(predict_outcome(cmd, xl, xh, yl, yh));
        endfunction

        function void check_result(logic need, logic err);
            t_rect_outcome want;
            if (outstanding.size() == 0) begin
                report($sformatf("result with no command outstanding: need_compute %b range_error %b",
                                 need, err));
                return;
            end
            want = outstanding.pop_front();
            if (need !== want.need_compute || err !== want.range_error)
                report($sformatf("mismatch: need_compute exp %b got %b, range_error exp %b got %b",
                                 want.need_compute, need, want.range_error, err));
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= ERR_SHOWN) $display("%0t %s", $time, msg);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rrdt_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rrdt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rrdt_cmd_if cmd_ch ();
    rrdt_res_if res_ch ();

    done_bitmap_board board;
    bit               idle_on = 1'b1;

    // last marked rectangle, replayed by some queries so that fully done answers show up
    bit [rrdt_pkg::COORD_W-1:0] mark_xl, mark_xh, mark_yl, mark_yh;

    rect_region_done_tracker_top #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: sampled at the edge, before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.need_compute, res_ch.range_error);
    end

    // result ready with random stall bursts while idling is enabled
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        int unsigned quiet;
        quiet = 0;
        do begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end while (quiet < QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // one command transfer, with an optional idle burst in front of it
    // valid is left high so back-to-back commands need no second assignment
    task automatic send_command(rrdt_pkg::t_cmd cmd, bit [rrdt_pkg::COORD_W-1:0] xl,
                                bit [rrdt_pkg::COORD_W-1:0] xh,
                                bit [rrdt_pkg::COORD_W-1:0] yl,
                                bit [rrdt_pkg::COORD_W-1:0] yh);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.x_lo    <= xl;
        cmd_ch.x_hi    <= xh;
        cmd_ch.y_lo    <= yl;
        cmd_ch.y_hi    <= yh;
        do @(posedge i_clk); while (!(cmd_ch.valid && cmd_ch.ready));
        board.note_command(cmd, xl, xh, yl, yh);
        if (cmd == rrdt_pkg::CMD_MARK) begin
            mark_xl = xl;
            mark_xh = xh;
            mark_yl = yl;
            mark_yh = yh;
        end
    endtask

    // drop valid and wait until every owed result has come back
    task automatic drain_commands();
        cmd_ch.valid <= 1'b0;
        while (board.outstanding.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [rrdt_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrdt_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // dimension writes carry junk above the register width, which must be dropped
    task automatic write_window(bit [rrdt_pkg::COORD_W-1:0] ox, bit [rrdt_pkg::COORD_W-1:0] oy,
                                bit [rrdt_pkg::DIM_W-1:0] w, bit [rrdt_pkg::DIM_W-1:0] h);
        int unsigned junk;
        write_reg(rrdt_pkg::REG_ORIGIN_X, ox);
        write_reg(rrdt_pkg::REG_ORIGIN_Y, oy);
        junk = $urandom_range(0, 511);
        write_reg(rrdt_pkg::REG_WIN_W,
                  rrdt_pkg::CFG_DATA_W'((junk << rrdt_pkg::DIM_W) | w));
        junk = $urandom_range(0, 511);
        write_reg(rrdt_pkg::REG_WIN_H,
                  rrdt_pkg::CFG_DATA_W'((junk << rrdt_pkg::DIM_W) | h));
        i_cfg_we <= 1'b0;
    endtask

    // one axis of a rectangle: mostly ordered and inside the window, some just outside
    // by one, some anywhere in the coordinate space
    function automatic void draw_span(input int unsigned base, input int unsigned extent,
                                      output bit [rrdt_pkg::COORD_W-1:0] lo,
                                      output bit [rrdt_pkg::COORD_W-1:0] hi);
        int unsigned top, a, b, t, style;
        top   = (base + extent > COORD_MAX) ? COORD_MAX : base + extent;
        a     = $urandom_range(base, top);
        b     = $urandom_range(base, top);
        style = $urandom_range(0, 19);
        if (style < 14) begin
            if (a > b) begin
                t = a;
                a = b;
                b = t;
            end
        end else if (style == 14 && base > 0) begin
            a = base - 1;
        end else if (style == 15 && base + extent < COORD_MAX) begin
            b = base + extent + 1;
        end else if (style == 16) begin
            a = $urandom_range(0, COORD_MAX);
            b = $urandom_range(0, COORD_MAX);
        end
        lo = a[rrdt_pkg::COORD_W-1:0];
        hi = b[rrdt_pkg::COORD_W-1:0];
    endfunction

    task automatic send_random_item();
        rrdt_pkg::t_cmd             cmd;
        bit [rrdt_pkg::COORD_W-1:0] xl, xh, yl, yh;
        int unsigned                pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      cmd = rrdt_pkg::CMD_MARK;
        else if (pick < 92) cmd = rrdt_pkg::CMD_QUERY;
        else if (pick < 96) cmd = rrdt_pkg::CMD_CLEAR;
        else                cmd = rrdt_pkg::CMD_RSVD;
        draw_span(board.org_x, board.eff_w(), xl, xh);
        draw_span(board.org_y, board.eff_h(), yl, yh);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // noise over the whole coordinate space
            xl = rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            xh = rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            yl = rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
            yh = rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX));
        end else if (cmd == rrdt_pkg::CMD_QUERY && pick < 4) begin
            xl = mark_xl;
            xh = mark_xh;
            yl = mark_yl;
            yh = mark_yh;
        end
        send_command(cmd, xl, xh, yl, yh);
    endtask

    task automatic run_phase(bit [rrdt_pkg::COORD_W-1:0] ox, bit [rrdt_pkg::COORD_W-1:0] oy,
                             bit [rrdt_pkg::DIM_W-1:0] w, bit [rrdt_pkg::DIM_W-1:0] h,
                             int unsigned items, bit with_idle);
        drain_commands();
        write_window(ox, oy, w, h);
        idle_on = with_idle;
        repeat (items) send_random_item();
    endtask

    task automatic run_directed();
        // reset window: origin 0,0 and 64 x 64
        send_command(rrdt_pkg::CMD_QUERY, 0, 64, 0, 64);     // fresh store, all pending
        send_command(rrdt_pkg::CMD_MARK, 0, 64, 0, 64);      // whole window
        send_command(rrdt_pkg::CMD_QUERY, 0, 64, 0, 64);     // all done now
        send_command(rrdt_pkg::CMD_QUERY, 5, 5, 0, 64);      // empty column span
        send_command(rrdt_pkg::CMD_QUERY, 0, 64, 9, 3);      // reversed rows, empty
        send_command(rrdt_pkg::CMD_MARK, 0, 65, 0, 64);      // one column past the window
        send_command(rrdt_pkg::CMD_QUERY, 0, 64, 0, 65);     // one row past the window
        send_command(rrdt_pkg::CMD_CLEAR, 16'hFFFF, 0, 16'hFFFF, 0);   // coordinates ignored
        send_command(rrdt_pkg::CMD_QUERY, 63, 64, 63, 64);   // corner cell after clear
        send_command(rrdt_pkg::CMD_MARK, 63, 64, 63, 64);
        send_command(rrdt_pkg::CMD_QUERY, 63, 64, 63, 64);
        send_command(rrdt_pkg::CMD_QUERY, 62, 64, 63, 64);   // neighbor still clear
        send_command(rrdt_pkg::CMD_MARK, 0, 1, 0, 64);       // first column
        send_command(rrdt_pkg::CMD_QUERY, 0, 1, 0, 64);
        send_command(rrdt_pkg::CMD_RSVD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(rrdt_pkg::CMD_MARK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_commands();

        // origin near the top of the coordinate space, oversized window saturates
        write_window(16'hFFC0, 16'hFFBF, 7'd127, 7'd100);
        send_command(rrdt_pkg::CMD_QUERY, 16'hFFC0, 16'hFFFF, 16'hFFBF, 16'hFFFF);
        send_command(rrdt_pkg::CMD_MARK, 16'hFFC0, 16'hFFFF, 16'hFFBF, 16'hFFFF);
        send_command(rrdt_pkg::CMD_QUERY, 16'hFFC0, 16'hFFFF, 16'hFFBF, 16'hFFFF);
        // column below origin
        send_command(rrdt_pkg::CMD_MARK, 16'hFFBF, 16'hFFC1, 16'hFFBF, 16'hFFC0);
        // row below origin
        send_command(rrdt_pkg::CMD_QUERY, 16'hFFC0, 16'hFFC1, 16'hFFBE, 16'hFFC0);
        // empty
        send_command(rrdt_pkg::CMD_QUERY, 16'hFFC0, 16'hFFC0, 16'hFFFF, 16'h0000);
    endtask

    initial begin
        board = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= '0;
        i_cfg_data     <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= rrdt_pkg::CMD_MARK;
        cmd_ch.x_lo    <= '0;
        cmd_ch.x_hi    <= '0;
        cmd_ch.y_lo    <= '0;
        cmd_ch.y_hi    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // the block sweeps its store after reset; the first transfer waits for ready
        run_directed();

        run_phase(16'd0, 16'd0, 7'd64, 7'd64, 250, 1'b1);
        run_phase(16'hFFC0, 16'hFFBF, 7'd127, 7'd100, 150, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 7'd0, 7'd0, 60, 1'b0);        // zero-size window
        run_phase(rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  7'd1, 7'd64, 150, 1'b1);
        run_phase(rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  7'd5, 7'd3, 150, 1'b1);
        run_phase(rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                  7'd64, 7'd1, 150, 1'b1);
        repeat (3)
            run_phase(rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                      rrdt_pkg::COORD_W'($urandom_range(0, COORD_MAX)),
                      rrdt_pkg::DIM_W'($urandom_range(0, 127)),
                      rrdt_pkg::DIM_W'($urandom_range(0, 127)), 100, 1'b1);
        // closing stretch without idle or stall bursts on either side
        run_phase(16'd0, 16'd0, 7'd64, 7'd64, 150, 1'b0);

        drain_commands();
        repeat (MAX_ROWS + 16) @(posedge i_clk);
        if (board.mismatches == 0 && board.outstanding.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
